// ----- sv/b128_pkg.sv -----
// ---------------------------------------------------------------------------
// b128_pkg
// Shared types, constants and the alphabet lookup for the base-128 encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package b128_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned SymW   = 7;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CarryW = 6;

  // last phase of a seven-byte group
  localparam logic [PhaseW-1:0] PhaseLast = 3'd6;

  // alphabet range boundaries and offsets
  localparam logic [SymW-1:0]  LowerEnd  = 7'd26;
  localparam logic [SymW-1:0]  UpperEnd  = 7'd52;
  localparam logic [SymW-1:0]  DigitEnd  = 7'd62;
  localparam logic [ByteW-1:0] LowerOfs  = 8'h61;  // 'a'
  localparam logic [ByteW-1:0] UpperOfs  = 8'h27;  // 'A' - 26
  localparam logic [ByteW-1:0] DigitOfs  = 8'hfc;  // '0' - 52, mod 256
  localparam logic [ByteW-1:0] HighOfs   = 8'h7e;  // 0xbc - 62

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [SymW-1:0]   sym_t;
  typedef logic [PhaseW-1:0] phase_t;
  typedef logic [CarryW-1:0] carry_t;

  // one output character with its end mark
  typedef struct packed {
    byte_t code;
    logic  last;
  } char_t;

  // the characters produced by one input byte
  typedef struct packed {
    char_t first;
    char_t second;
    logic  two;
  } char_pair_t;

  // map a 7-bit symbol to its character
  function automatic byte_t alphabet(input sym_t sym);
    byte_t ext;
    ext = {1'b0, sym};
    if (sym < LowerEnd) begin
      return ext + LowerOfs;
    end else if (sym < UpperEnd) begin
      return ext + UpperOfs;
    end else if (sym < DigitEnd) begin
      return ext + DigitOfs;
    end else begin
      return ext + HighOfs;
    end
  endfunction

endpackage

`default_nettype wire

// ----- sv/base128_byte_encoder.sv -----
// ---------------------------------------------------------------------------
// base128_byte_encoder
// Streams bytes into 7-bit symbols, seven bytes to eight characters, and
// flushes the held bits as a final character at the end of a message.
// ---------------------------------------------------------------------------
// channel | valid      | stall      | payload
// byte in | byte_valid | byte_stall | data_byte, last_byte
// char out| char_valid | char_stall | code_char, last_char
//
// A byte is registered on entry and then moves to the output register. Bytes
// that give one character flow at one per cycle while char_stall is low; a
// group end or message end gives two characters, and the second sits in a
// spare register while the next byte waits in the entry register.
// Reset clears the phase, held bits and all valid flags.
// Output stall holds the character register; input stall rises when the
// entry register cannot move on.
// ---------------------------------------------------------------------------
`default_nettype none

module base128_byte_encoder (
  input  var logic             clk,
  input  var logic             rst,
  input  var logic             byte_valid,
  output logic                 byte_stall,
  input  var b128_pkg::byte_t  data_byte,
  input  var logic             last_byte,
  output logic                 char_valid,
  input  var logic             char_stall,
  output b128_pkg::byte_t      code_char,
  output logic                 last_char
);
  import b128_pkg::*;

  // group state
  phase_t     phase;
  carry_t     carry;
  phase_t     phase_next;
  carry_t     carry_next;
  phase_t     phase_in;
  carry_t     mask;

  // entry register
  logic       s1_valid;
  byte_t      s1_data;
  logic       s1_last;
  phase_t     s1_phase;
  carry_t     s1_carry;

  // output register and spare for the second character
  logic       out_valid;
  char_t      out_char;
  logic       pend_valid;
  char_t      pend_char;

  char_pair_t chars;
  logic       accept;
  logic       out_free;
  logic       s1_move;
  logic       pend_move;

  // handshake
  assign out_free   = !out_valid || !char_stall;
  assign pend_move  = pend_valid && out_free;
  assign s1_move    = s1_valid && out_free && !pend_valid;
  assign byte_stall = s1_valid && !s1_move;
  assign accept     = byte_valid && !byte_stall;

  // next phase and held bits from the arriving byte
  assign phase_in = (phase > PhaseLast) ? PhaseLast : phase;
  assign mask     = carry_t'((8'd1 << (phase_in + phase_t'(1))) - 8'd1);

  always_comb begin
    if (last_byte || (phase_in == PhaseLast)) begin
      phase_next = '0;
      carry_next = '0;
    end else begin
      phase_next = phase_in + phase_t'(1);
      carry_next = data_byte[CarryW-1:0] & mask;
    end
  end

  // group state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      carry <= '0;
    end else if (accept) begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

  // entry register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data  <= data_byte;
      s1_last  <= last_byte;
      s1_phase <= phase;
      s1_carry <= carry;
    end
  end

  // symbol split and alphabet lookup
  b128_pack u_pack (
    .data  (s1_data),
    .last  (s1_last),
    .phase (s1_phase),
    .carry (s1_carry),
    .chars (chars)
  );

  // output register and spare register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_move) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (s1_move) begin
        out_valid  <= 1'b1;
        pend_valid <= chars.two;
      end else if (out_free) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      out_char <= pend_char;
    end else if (s1_move) begin
      out_char  <= chars.first;
      pend_char <= chars.second;
    end
  end

  assign char_valid = out_valid;
  assign code_char  = out_char.code;
  assign last_char  = out_char.last;

endmodule

`default_nettype wire

// ----- sv/b128_pack.sv -----
// ---------------------------------------------------------------------------
// b128_pack
// Splits one registered byte into its symbols and maps them to characters.
// ---------------------------------------------------------------------------
`default_nettype none

module b128_pack (
  input  var b128_pkg::byte_t      data,
  input  var logic                 last,
  input  var b128_pkg::phase_t     phase,
  input  var b128_pkg::carry_t     carry,
  output b128_pkg::char_pair_t     chars
);
  import b128_pkg::*;

  phase_t               p;
  phase_t               hi_shift;
  phase_t               lo_shift;
  logic [CarryW+ByteW-1:0] joined;
  logic [CarryW+ByteW-1:0] joined_sh;
  logic [ByteW+SymW-2:0]   lo_wide;
  sym_t                 sym_first;
  sym_t                 sym_second;

  // phase seven is never reached; treat it as the last phase
  assign p = (phase > PhaseLast) ? PhaseLast : phase;

  assign hi_shift = p + phase_t'(1);
  assign lo_shift = PhaseLast - p;

  // first symbol: held bits on top, high bits of the byte below
  assign joined    = {carry, data};
  assign joined_sh = joined >> hi_shift;
  assign sym_first = joined_sh[SymW-1:0];

  // second symbol: low bits of the byte, zero padded on the right
  assign lo_wide    = {{(SymW-2){1'b0}}, data} << lo_shift;
  assign sym_second = lo_wide[SymW-1:0];

  // second character on a group end or a message end
  always_comb begin
    chars.first.code  = alphabet(sym_first);
    chars.first.last  = 1'b0;
    chars.second.code = alphabet(sym_second);
    chars.second.last = last;
    chars.two         = last || (p == PhaseLast);
  end

endmodule

`default_nettype wire
